// ===== sv/nms_pkg.sv =====
// shared types, constants and helpers for the detection filter with box suppression
`default_nettype none
package nms_pkg;

  localparam int unsigned MaxCandDefault = 1024;

  localparam logic [15:0] BodyThrReset = 16'd32768;
  localparam logic [15:0] HeadThrReset = 16'd32768;
  localparam logic [15:0] IouThrReset  = 16'd29491;
  localparam logic [6:0]  MaxBoxReset  = 7'd64;
  localparam logic [6:0]  OutLimit     = 7'd64;

  // 0.1 in Q0.16, rounded up
  localparam logic [15:0] ScoreFloor   = 16'd6554;
  // 2.0 pixels in 12.4
  localparam logic signed [16:0] MinSize = 17'sd32;
  localparam logic [3:0]  HeadClass    = 4'd1;

  typedef enum logic [2:0] {
    CFG_BODY_THR = 3'd0,
    CFG_HEAD_THR = 3'd1,
    CFG_IOU_THR  = 3'd2,
    CFG_MAX_BOX  = 3'd3,
    CFG_LOWERED  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_PASS_WAIT,
    ST_PASS_IOU,
    ST_PASS_END,
    ST_MARK,
    ST_OUT
  } nms_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_GEO,
    U_AREA,
    U_INTER,
    U_UNI,
    U_PLO,
    U_PHI,
    U_CMP
  } iou_state_e;

  typedef struct packed {
    logic signed [15:0] x_left;
    logic signed [15:0] y_top;
    logic signed [15:0] x_right;
    logic signed [15:0] y_bottom;
    logic [15:0]        score;
    logic [3:0]         class_code;
    logic               last_in;
  } cand_in_t;

  typedef struct packed {
    logic               valid_res;
    logic [3:0]         box_class;
    logic [15:0]        box_score;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [15:0]        box_w;
    logic [15:0]        box_h;
    logic               last_out;
    logic               overflow;
  } res_t;

  // stored candidate
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        score;
    logic [3:0]         cls;
  } cand_t;

  typedef struct packed {
    logic        start;
    logic        check;
    cand_t       a;
    logic [31:0] area_a;
    cand_t       b;
    logic [15:0] thr;
  } iou_req_t;

  typedef struct packed {
    logic        done;
    logic        suppress;
    logic [31:0] area_b;
  } iou_rsp_t;

  function automatic res_t make_res(cand_t c, logic last, logic ovf);
    res_t r;
    r.valid_res = 1'b1;
    r.box_class = c.cls;
    r.box_score = c.score;
    r.box_x     = c.x;
    r.box_y     = c.y;
    r.box_w     = c.w;
    r.box_h     = c.h;
    r.last_out  = last;
    r.overflow  = ovf;
    return r;
  endfunction

  function automatic res_t empty_res(logic ovf);
    res_t r;
    r          = '0;
    r.last_out = 1'b1;
    r.overflow = ovf;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nms_cand_mem.sv =====
// candidate store and per-entry done flags, registered read
`default_nettype none
module nms_cand_mem import nms_pkg::*; #(
  parameter int unsigned Depth = MaxCandDefault,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire cand_t            wr_data_i,
  input  wire logic             done_we_i,
  input  wire logic [AddrW-1:0] done_addr_i,
  input  wire logic             done_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output cand_t                 rd_data_o,
  output logic                  rd_done_o
);

  cand_t entry_mem [Depth];
  logic  done_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= entry_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_we_i) begin
      done_mem[done_addr_i] <= done_data_i;
    end
    if (rd_en_i) begin
      rd_done_o <= done_mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/nms_iou_unit.sv =====
// iterative overlap test around one shared 17x17 multiplier
`default_nettype none
module nms_iou_unit import nms_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire iou_req_t req_i,
  output iou_rsp_t      rsp_o
);

  iou_state_e state_q, state_d;
  cand_t       b_q;
  logic        chk_q;
  logic [15:0] dx_q, dy_q;
  logic        ovl_q;
  logic [31:0] areab_q, inter_q;
  logic [32:0] uni_q;
  logic [33:0] plo_q, phi_q;
  logic        done_q, done_d;
  logic        sup_q, sup_d;

  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;

  logic signed [17:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [17:0] x1, x2, y1, y2, dx, dy;
  logic [49:0] lhs, rhs;

  // overlap extents in 18-bit signed
  always_comb begin
    ax0 = {{2{req_i.a.x[15]}}, req_i.a.x};
    ay0 = {{2{req_i.a.y[15]}}, req_i.a.y};
    bx0 = {{2{b_q.x[15]}}, b_q.x};
    by0 = {{2{b_q.y[15]}}, b_q.y};
    ax1 = ax0 + $signed({2'b00, req_i.a.w});
    ay1 = ay0 + $signed({2'b00, req_i.a.h});
    bx1 = bx0 + $signed({2'b00, b_q.w});
    by1 = by0 + $signed({2'b00, b_q.h});
    x1  = (ax0 > bx0) ? ax0 : bx0;
    y1  = (ay0 > by0) ? ay0 : by0;
    x2  = (ax1 < bx1) ? ax1 : bx1;
    y2  = (ay1 < by1) ? ay1 : by1;
    dx  = x2 - x1;
    dy  = y2 - y1;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      U_AREA: begin
        mul_a = {1'b0, b_q.w};
        mul_b = {1'b0, b_q.h};
      end
      U_INTER: begin
        mul_a = {1'b0, dx_q};
        mul_b = {1'b0, dy_q};
      end
      U_PLO: begin
        mul_a = {1'b0, req_i.thr};
        mul_b = uni_q[16:0];
      end
      U_PHI: begin
        mul_a = {1'b0, req_i.thr};
        mul_b = {1'b0, uni_q[32:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign lhs = {2'b00, inter_q, 16'd0};
  assign rhs = 50'(plo_q) + {phi_q[32:0], 17'd0};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    sup_d   = sup_q;
    unique case (state_q)
      U_IDLE:  if (req_i.start) state_d = U_GEO;
      U_GEO:   state_d = U_AREA;
      U_AREA: begin
        if (chk_q && ovl_q) begin
          state_d = U_INTER;
        end else begin
          sup_d   = 1'b0;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      U_INTER: state_d = U_UNI;
      U_UNI:   state_d = U_PLO;
      U_PLO:   state_d = U_PHI;
      U_PHI:   state_d = U_CMP;
      U_CMP: begin
        sup_d   = lhs > rhs;
        done_d  = 1'b1;
        state_d = U_IDLE;
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
      sup_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      sup_q   <= sup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && req_i.start) begin
      b_q   <= req_i.b;
      chk_q <= req_i.check;
    end
    if (state_q == U_GEO) begin
      dx_q  <= dx[15:0];
      dy_q  <= dy[15:0];
      ovl_q <= (dx > 18'sd0) && (dy > 18'sd0);
    end
    if (state_q == U_AREA)  areab_q <= mul_p[31:0];
    if (state_q == U_INTER) inter_q <= mul_p[31:0];
    if (state_q == U_UNI)   uni_q <= 33'(req_i.area_a) + 33'(areab_q) - 33'(inter_q);
    if (state_q == U_PLO)   plo_q <= mul_p;
    if (state_q == U_PHI)   phi_q <= mul_p;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.suppress = sup_q;
  assign rsp_o.area_b   = areab_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == U_IDLE)
    else $error("overlap unit finished while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == U_IDLE && req_i.start) |=> state_q == U_GEO)
    else $error("overlap unit ignored a start");
  a_sup_needs_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && sup_q) |-> chk_q)
    else $error("suppression without check");

endmodule
`default_nettype wire

// ===== sv/detection_filter_nms.sv =====
// detection filter top: candidate load, selection passes with overlap suppression, output
//
//  channel | direction | handshake              | payload
//  in      | in        | in_valid_i/in_ready_o   | in_data_i  (cand_in_t)
//  out     | out       | out_valid_o/out_ready_i | out_data_o (res_t)
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// candidates load one per cycle; ready drops after the last item of a frame.
// each selection pass walks all stored entries: a retired entry is only read, while a live
// one also goes through the overlap unit and its shared multiplier, with or without a check.
// a frame takes at most max(1, min(max_boxes,64)) passes, each result waits for its transfer.
// reset clears control state only; the store needs no clearing pass.
`default_nettype none
module detection_filter_nms import nms_pkg::*; #(
  parameter int unsigned MAX_CANDIDATES = MaxCandDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire cand_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output res_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(MAX_CANDIDATES);
  localparam int unsigned CntW  = $clog2(MAX_CANDIDATES + 1);

  logic [15:0] body_q, head_q, iou_q;
  logic [6:0]  maxb_q;
  logic        low_q;

  nms_state_e  state_q, state_d;
  logic [CntW-1:0] count_q, count_d, k_q, k_d;
  logic        ovf_q, ovf_d;
  logic [6:0]  n_q, n_d;
  logic        best_vld_q, best_vld_d, have_ch_q, have_ch_d;
  logic        out_vld_q, out_vld_d;
  cand_t       best_q, best_d, chosen_q, chosen_d, cur_q, cur_d;
  logic [31:0] best_area_q, best_area_d, chosen_area_q, chosen_area_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  res_t        out_q, out_d;

  logic        wr_en, done_we, done_data, rd_en;
  logic [AddrW-1:0] done_addr;
  cand_t       rd_data, new_cand;
  logic        rd_done;
  iou_req_t    iou_req;
  iou_rsp_t    iou_rsp;

  logic [15:0] thr;
  logic        score_ok, keep;
  logic signed [16:0] wdiff, hdiff;
  logic [6:0]  limit;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= BodyThrReset;
      head_q <= HeadThrReset;
      iou_q  <= IouThrReset;
      maxb_q <= MaxBoxReset;
      low_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BODY_THR: body_q <= cfg_wdata_i;
        CFG_HEAD_THR: head_q <= cfg_wdata_i;
        CFG_IOU_THR:  iou_q  <= cfg_wdata_i;
        CFG_MAX_BOX:  maxb_q <= cfg_wdata_i[6:0];
        CFG_LOWERED:  low_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // admission filter
  always_comb begin
    thr   = (in_data_i.class_code == HeadClass) ? head_q : body_q;
    wdiff = $signed({in_data_i.x_right[15], in_data_i.x_right})
          - $signed({in_data_i.x_left[15], in_data_i.x_left});
    hdiff = $signed({in_data_i.y_bottom[15], in_data_i.y_bottom})
          - $signed({in_data_i.y_top[15], in_data_i.y_top});
    score_ok = (in_data_i.score >= ScoreFloor) &&
               (low_q ? ({in_data_i.score, 2'b00} >= (18'(thr) * 18'd3))
                      : (in_data_i.score >= thr));
    keep = score_ok && (wdiff >= MinSize) && (hdiff >= MinSize);
    new_cand.x     = in_data_i.x_left;
    new_cand.y     = in_data_i.y_top;
    new_cand.w     = wdiff[15:0];
    new_cand.h     = hdiff[15:0];
    new_cand.score = in_data_i.score;
    new_cand.cls   = in_data_i.class_code;
    limit = (maxb_q > OutLimit) ? OutLimit : maxb_q;
  end

  assign iou_req.start  = (state_q == ST_PASS_WAIT) && !rd_done;
  assign iou_req.check  = have_ch_q && (iou_q != 16'd0);
  assign iou_req.a      = chosen_q;
  assign iou_req.area_a = chosen_area_q;
  assign iou_req.b      = rd_data;
  assign iou_req.thr    = iou_q;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    k_d           = k_q;
    ovf_d         = ovf_q;
    n_d           = n_q;
    best_vld_d    = best_vld_q;
    have_ch_d     = have_ch_q;
    out_vld_d     = out_vld_q;
    best_d        = best_q;
    best_area_d   = best_area_q;
    best_idx_d    = best_idx_q;
    chosen_d      = chosen_q;
    chosen_area_d = chosen_area_q;
    cur_d         = cur_q;
    out_d         = out_q;
    wr_en         = 1'b0;
    done_we       = 1'b0;
    done_data     = 1'b0;
    done_addr     = count_q[AddrW-1:0];
    rd_en         = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (keep) begin
            if (count_q < CntW'(MAX_CANDIDATES)) begin
              wr_en   = 1'b1;
              done_we = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_data_i.last_in) begin
            k_d        = '0;
            n_d        = '0;
            best_vld_d = 1'b0;
            have_ch_d  = 1'b0;
            state_d    = ST_PASS_RD;
          end
        end
      end
      ST_PASS_RD: begin
        if (k_q == count_q) begin
          state_d = ST_PASS_END;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_PASS_WAIT;
        end
      end
      ST_PASS_WAIT: begin
        cur_d = rd_data;
        if (rd_done) begin
          k_d     = k_q + 1'b1;
          state_d = ST_PASS_RD;
        end else begin
          state_d = ST_PASS_IOU;
        end
      end
      ST_PASS_IOU: begin
        if (iou_rsp.done) begin
          if (iou_rsp.suppress) begin
            done_we   = 1'b1;
            done_data = 1'b1;
            done_addr = k_q[AddrW-1:0];
          end else if (!best_vld_q ||
                       ((iou_q != 16'd0) && (cur_q.score > best_q.score))) begin
            // strict compare keeps the earliest entry among equal scores
            best_d      = cur_q;
            best_area_d = iou_rsp.area_b;
            best_idx_d  = k_q[AddrW-1:0];
            best_vld_d  = 1'b1;
          end
          k_d     = k_q + 1'b1;
          state_d = ST_PASS_RD;
        end
      end
      ST_PASS_END: begin
        if (have_ch_q) begin
          out_d     = make_res(chosen_q, !best_vld_q, ovf_q);
          out_vld_d = 1'b1;
          state_d   = ST_OUT;
        end else if (!best_vld_q || (limit == 7'd0)) begin
          out_d     = empty_res(ovf_q);
          out_vld_d = 1'b1;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        chosen_d      = best_q;
        chosen_area_d = best_area_q;
        have_ch_d     = 1'b1;
        done_we       = 1'b1;
        done_data     = 1'b1;
        done_addr     = best_idx_q;
        best_vld_d    = 1'b0;
        k_d           = '0;
        if ((n_q + 7'd1) == limit) begin
          out_d     = make_res(best_q, 1'b1, ovf_q);
          out_vld_d = 1'b1;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_PASS_RD;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          out_vld_d = 1'b0;
          n_d       = n_q + 7'd1;
          if (out_q.last_out) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_MARK;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      k_q        <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      best_vld_q <= 1'b0;
      have_ch_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      k_q        <= k_d;
      ovf_q      <= ovf_d;
      n_q        <= n_d;
      best_vld_q <= best_vld_d;
      have_ch_q  <= have_ch_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q        <= best_d;
    best_area_q   <= best_area_d;
    best_idx_q    <= best_idx_d;
    chosen_q      <= chosen_d;
    chosen_area_q <= chosen_area_d;
    cur_q         <= cur_d;
    out_q         <= out_d;
  end

  nms_cand_mem #(
    .Depth(MAX_CANDIDATES)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (count_q[AddrW-1:0]),
    .wr_data_i   (new_cand),
    .done_we_i   (done_we),
    .done_addr_i (done_addr),
    .done_data_i (done_data),
    .rd_en_i     (rd_en),
    .rd_addr_i   (k_q[AddrW-1:0]),
    .rd_data_o   (rd_data),
    .rd_done_o   (rd_done)
  );

  nms_iou_unit u_iou (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iou_req),
    .rsp_o  (iou_rsp)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_load_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("loading while a result is pending");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_CANDIDATES))
    else $error("candidate count beyond store");
  a_iou_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iou_rsp.done |-> state_q == ST_PASS_IOU)
    else $error("overlap result outside a pass");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |-> out_data_o.last_out)
    else $error("empty result not marked last");
  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= OutLimit)
    else $error("too many results in a frame");

endmodule
`default_nettype wire
